FILE: rtl/core/sfbit_pkg.sv
// ----------------------------------------------------------------------------
// sfbit_pkg
// Shared constants and types for the serial frame buffer with idle timeout.
// ----------------------------------------------------------------------------
package sfbit_pkg;

    localparam int BUFFER_BYTES = 256;
    localparam int ADDR_W       = $clog2(BUFFER_BYTES);
    localparam int CAPACITY     = BUFFER_BYTES - 1;
    localparam int POS_W        = ((ADDR_W > 8) ? ADDR_W : 8) + 1;

    localparam logic [2:0] KIND_RX    = 3'd0;
    localparam logic [2:0] KIND_TICK  = 3'd1;
    localparam logic [2:0] KIND_READ  = 3'd2;
    localparam logic [2:0] KIND_PEEK  = 3'd3;
    localparam logic [2:0] KIND_CLEAR = 3'd4;

    localparam logic [7:0] CHAR_LF = 8'd10;
    localparam logic [7:0] CHAR_CR = 8'd13;

    localparam logic MODE_TEXT   = 1'b0;
    localparam logic MODE_BINARY = 1'b1;

    localparam logic REG_FRAME_MODE   = 1'b0;
    localparam logic REG_IDLE_TIMEOUT = 1'b1;

    // Status of one item, taken after the state update.
    typedef struct packed {
        logic              data_valid;
        logic              accepted;
        logic              frame_done;
        logic              overflowed;
        logic [ADDR_W-1:0] fill_length;
        logic [ADDR_W-1:0] read_position;
    } t_result;

    // Access to the frame store requested by the controller.
    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [7:0]        wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } t_mem_req;

endpackage

FILE: rtl/core/sfbit_store.sv
// ----------------------------------------------------------------------------
// sfbit_store
// Frame store: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sfbit_store (
    input  logic                 i_clk,
    input  sfbit_pkg::t_mem_req  i_req,
    output logic [7:0]           o_rd_data
);

    logic [7:0] r_mem [sfbit_pkg::BUFFER_BYTES];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/core/sfbit_ctrl.sv
// ----------------------------------------------------------------------------
// sfbit_ctrl
// Frame state, configuration registers and the per-beat update that drives
// the frame store.
// ----------------------------------------------------------------------------
module sfbit_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    input  logic                 i_accept,
    input  logic [2:0]           i_kind,
    input  logic [7:0]           i_rx_byte,
    input  logic [7:0]           i_peek_offset,
    output sfbit_pkg::t_mem_req  o_req,
    output sfbit_pkg::t_result   o_result
);

    localparam int AW = sfbit_pkg::ADDR_W;
    localparam int PW = sfbit_pkg::POS_W;

    logic          r_mode;
    logic [31:0]   r_timeout;
    logic [AW-1:0] r_count, n_count;
    logic [AW-1:0] r_rd_idx, n_rd_idx;
    logic [31:0]   r_idle, n_idle;
    logic          r_done, n_done;
    logic          r_ovf, n_ovf;
    logic          valid, accepted;
    logic [PW-1:0] peek_pos;

    assign peek_pos = PW'(r_rd_idx) + PW'(i_peek_offset);

    always_comb begin
        n_count  = r_count;
        n_rd_idx = r_rd_idx;
        n_idle   = r_idle;
        n_done   = r_done;
        n_ovf    = r_ovf;
        valid    = 1'b0;
        accepted = 1'b0;
        o_req    = '0;
        o_req.wr_addr = r_count;
        o_req.wr_data = i_rx_byte;
        o_req.rd_addr = r_rd_idx;
        case (i_kind)
            sfbit_pkg::KIND_RX: begin
                if (!r_done) begin
                    accepted = 1'b1;
                    n_idle   = '0;
                    if (r_mode == sfbit_pkg::MODE_TEXT && i_rx_byte == sfbit_pkg::CHAR_CR) begin
                        n_done = 1'b1;
                    end else if (r_mode == sfbit_pkg::MODE_TEXT
                                 && i_rx_byte == sfbit_pkg::CHAR_LF) begin
                        n_idle = '0;
                    end else if (r_count < AW'(sfbit_pkg::CAPACITY)) begin
                        o_req.wr_en = i_accept;
                        n_count     = r_count + 1'b1;
                    end else begin
                        n_ovf = 1'b1;
                    end
                end
            end
            sfbit_pkg::KIND_TICK: begin
                if (!r_done) begin
                    if (r_idle != '1) begin
                        n_idle = r_idle + 1'b1;
                    end
                    if (r_mode == sfbit_pkg::MODE_BINARY && r_count != '0
                        && n_idle > r_timeout) begin
                        n_done = 1'b1;
                    end
                end
            end
            sfbit_pkg::KIND_READ: begin
                if (r_rd_idx < r_count) begin
                    valid       = 1'b1;
                    o_req.rd_en = i_accept;
                    n_rd_idx    = r_rd_idx + 1'b1;
                end
            end
            sfbit_pkg::KIND_PEEK: begin
                o_req.rd_addr = peek_pos[AW-1:0];
                if (peek_pos < PW'(r_count)) begin
                    valid       = 1'b1;
                    o_req.rd_en = i_accept;
                end
            end
            sfbit_pkg::KIND_CLEAR: begin
                n_count  = '0;
                n_rd_idx = '0;
                n_idle   = '0;
                n_done   = 1'b0;
                n_ovf    = 1'b0;
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= sfbit_pkg::MODE_TEXT;
            r_timeout <= 32'd100;
            r_count   <= '0;
            r_rd_idx  <= '0;
            r_idle    <= '0;
            r_done    <= 1'b0;
            r_ovf     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    sfbit_pkg::REG_FRAME_MODE:   r_mode    <= i_cfg_data[0];
                    sfbit_pkg::REG_IDLE_TIMEOUT: r_timeout <= i_cfg_data;
                    default:                     r_mode    <= r_mode;
                endcase
            end
            if (i_accept) begin
                r_count  <= n_count;
                r_rd_idx <= n_rd_idx;
                r_idle   <= n_idle;
                r_done   <= n_done;
                r_ovf    <= n_ovf;
            end
        end
    end

    always_comb begin
        o_result.data_valid    = valid;
        o_result.accepted      = accepted;
        o_result.frame_done    = n_done;
        o_result.overflowed    = n_ovf;
        o_result.fill_length   = n_count;
        o_result.read_position = n_rd_idx;
    end

endmodule

FILE: rtl/core/sfbit_out.sv
// ----------------------------------------------------------------------------
// sfbit_out
// Two result stages: the first waits for the store's read data, the second
// is the output register that holds a beat until it is taken.
// ----------------------------------------------------------------------------
module sfbit_out (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  sfbit_pkg::t_result  i_result,
    input  logic [7:0]          i_rd_data,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output sfbit_pkg::t_result  o_result,
    output logic [7:0]          o_data
);

    logic               r_s1_valid;
    sfbit_pkg::t_result r_s1_res;
    logic               r_o_valid;
    sfbit_pkg::t_result r_o_res;
    logic [7:0]         r_o_data;
    logic               take_out;

    assign take_out   = !r_o_valid || i_out_ready;
    assign o_in_ready = !r_s1_valid || take_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (take_out) begin
                r_o_valid <= r_s1_valid;
            end
            if (o_in_ready) begin
                r_s1_valid <= i_accept;
            end
        end
    end

    // The read data register only changes on an accepted beat, which is also
    // the edge where the first stage moves on, so it is still valid here.
    always_ff @(posedge i_clk) begin
        if (take_out && r_s1_valid) begin
            r_o_res  <= r_s1_res;
            r_o_data <= r_s1_res.data_valid ? i_rd_data : 8'd0;
        end
        if (i_accept) begin
            r_s1_res <= i_result;
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_result    = r_o_res;
    assign o_data      = r_o_data;

endmodule

FILE: rtl/core/serial_frame_buffer_idle_timeout_unit.sv
// ----------------------------------------------------------------------------
// serial_frame_buffer_idle_timeout_unit
// Collects received bytes into a frame store and serves reads and peeks.
// ----------------------------------------------------------------------------
// The unit takes one command beat per clock while o_in_ready is high and
// returns one result beat for each, by way of the registered store read and
// the output register. Commands are receive byte, tick, read, peek and clear;
// the result carries the fetched byte and the buffer status after the update.
// The store holds up to 255 bytes and needs no clearing after reset. Outside
// reset, configuration writes are taken at any edge with the write enable high.
module serial_frame_buffer_idle_timeout_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_kind,
    input  logic [7:0]  i_rx_byte,
    input  logic [7:0]  i_peek_offset,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_data,
    output logic        o_data_valid,
    output logic        o_accepted,
    output logic        o_frame_done,
    output logic        o_overflowed,
    output logic [7:0]  o_fill_length,
    output logic [7:0]  o_read_position
);

    logic                accept;
    sfbit_pkg::t_mem_req req;
    sfbit_pkg::t_result  step_res;
    sfbit_pkg::t_result  out_res;
    logic [7:0]          rd_data;

    assign accept = i_in_valid && o_in_ready;

    sfbit_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_accept      (accept),
        .i_kind        (i_kind),
        .i_rx_byte     (i_rx_byte),
        .i_peek_offset (i_peek_offset),
        .o_req         (req),
        .o_result      (step_res)
    );

    sfbit_store u_store (
        .i_clk     (i_clk),
        .i_req     (req),
        .o_rd_data (rd_data)
    );

    sfbit_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_result    (step_res),
        .i_rd_data   (rd_data),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_result    (out_res),
        .o_data      (o_data)
    );

    assign o_data_valid    = out_res.data_valid;
    assign o_accepted      = out_res.accepted;
    assign o_frame_done    = out_res.frame_done;
    assign o_overflowed    = out_res.overflowed;
    assign o_fill_length   = 8'(out_res.fill_length);
    assign o_read_position = 8'(out_res.read_position);

endmodule
